// ===== src/mma_pkg.sv =====
// Shared constants and controller/datapath handshake types for the moving average block.
`default_nettype none
package mma_pkg;

   localparam int SAMPLE_W  = 32;
   localparam int CHANNEL_W = 3;
   localparam int WINDOW_W  = 7;
   localparam int USED_W    = 7;

   typedef struct packed {
      logic accept;
      logic mem_read;
      logic update;
      logic div_start;
      logic out_load;
   } mma_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic out_free;
   } mma_status_type;

endpackage
`default_nettype wire

// ===== src/mma_req_if.sv =====
// Input channel: one beat carries a channel number and a sample.
`default_nettype none
interface mma_req_if
   import mma_pkg::*;
();

   logic                        valid;
   logic                        ready;
   logic [CHANNEL_W-1:0]        channel;
   logic signed [SAMPLE_W-1:0]  sample_value;

   modport source (output valid, channel, sample_value, input ready);
   modport sink (input valid, channel, sample_value, output ready);
endinterface
`default_nettype wire

// ===== src/mma_rsp_if.sv =====
// Result channel: one beat carries the channel, the average and the sample count.
`default_nettype none
interface mma_rsp_if
   import mma_pkg::*;
();

   logic                        valid;
   logic                        ready;
   logic [CHANNEL_W-1:0]        result_channel;
   logic signed [SAMPLE_W-1:0]  average_value;
   logic [USED_W-1:0]           samples_used;

   modport source (output valid, result_channel, average_value, samples_used, input ready);
   modport sink (input valid, result_channel, average_value, samples_used, output ready);
endinterface
`default_nettype wire

// ===== src/mma_ctrl.sv =====
// Controller state machine sequencing one sample through read, update, divide and output.
`default_nettype none
module mma_ctrl
   import mma_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire mma_status_type  status,
   output mma_cmd_type          cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_UPD   = 3'd2;
   localparam logic [2:0] S_START = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_READ;
            end
         end
         S_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = S_UPD;
         end
         S_UPD: begin
            cmd.update = 1'b1;
            state_in   = S_START;
         end
         S_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (!status.div_busy) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (state_ff == S_READ))
      else $error("accepted beat did not start a read");

   a_out_only_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (status.out_free && !req_ready))
      else $error("result loaded while output slot busy");

   a_div_follows_start: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> (state_ff == S_DIV))
      else $error("divide not entered after start");

endmodule
`default_nettype wire

// ===== src/mma_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module mma_div #(
   parameter int DIVIDEND_W = 38,
   parameter int DIVISOR_W  = 7
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       busy,
   output logic [DIVIDEND_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  dsr_ff;
   logic [DIVISOR_W:0]    partial;
   logic                  take;
   logic [DIVISOR_W:0]    diff;

   assign partial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign take    = (partial >= {1'b0, dsr_ff});
   assign diff    = partial - {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(DIVIDEND_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= take ? diff[DIVISOR_W-1:0] : partial[DIVISOR_W-1:0];
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], take};
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ===== src/mma_dp.sv =====
// Datapath: sample ring memory, per-channel state, divider and output register.
`default_nettype none
module mma_dp
   import mma_pkg::*;
#(
   parameter int CHANNELS   = 8,
   parameter int WINDOW_MAX = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_enable,
   input  wire logic [WINDOW_W-1:0]        csr_write_data,
   input  wire logic [CHANNEL_W-1:0]       in_channel,
   input  wire logic signed [SAMPLE_W-1:0] in_sample,
   input  wire mma_cmd_type                cmd,
   output mma_status_type                  status,
   input  wire logic                       out_ready,
   output logic                            out_valid,
   output logic [CHANNEL_W-1:0]            out_channel,
   output logic signed [SAMPLE_W-1:0]      out_average,
   output logic [USED_W-1:0]               out_used
);

   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int POS_W    = $clog2(WINDOW_MAX);
   localparam int FILL_W   = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W    = SAMPLE_W + POS_W;
   localparam int ADDR_W   = CH_W + POS_W;
   localparam int DEPTH    = 2 ** ADDR_W;
   localparam int CMP_W    = (FILL_W > WINDOW_W) ? FILL_W : WINDOW_W;
   localparam int CH_IN_N  = 2 ** CHANNEL_W;

   logic [CH_W-1:0]            ch_map [CH_IN_N];
   logic [CH_W-1:0]            ch_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic [FILL_W-1:0]          window_ff;
   logic [POS_W-1:0]           pos_ff  [CHANNELS];
   logic [FILL_W-1:0]          fill_ff [CHANNELS];
   logic signed [SUM_W-1:0]    sum_ff  [CHANNELS];
   logic signed [SAMPLE_W-1:0] ring    [DEPTH];
   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic signed [SUM_W-1:0]    total_ff;
   logic [FILL_W-1:0]          count_ff;
   logic                       neg_ff;
   logic                       out_valid_ff;
   logic [CHANNEL_W-1:0]       out_channel_ff;
   logic signed [SAMPLE_W-1:0] out_average_ff;
   logic [USED_W-1:0]          out_used_ff;

   logic [CMP_W-1:0]           wr_wide;
   logic [FILL_W-1:0]          window_in;
   logic [POS_W-1:0]           pos_eff;
   logic [FILL_W-1:0]          pos_next_wide;
   logic [POS_W-1:0]           pos_in;
   logic                       full;
   logic [FILL_W-1:0]          fill_in;
   logic signed [SUM_W-1:0]    old_ext;
   logic signed [SUM_W-1:0]    sum_in;
   logic [ADDR_W-1:0]          addr;
   logic [SUM_W-1:0]           magnitude;
   logic                       div_busy;
   logic [SUM_W-1:0]           quotient;
   logic [SAMPLE_W-1:0]        quo_low;
   logic [CH_W+CHANNEL_W-1:0]  ch_wide;
   logic [FILL_W+USED_W-1:0]   used_wide;

   for (genvar i = 0; i < CH_IN_N; i++) begin : g_ch_map
      assign ch_map[i] = CH_W'(i % CHANNELS);
   end

   // Clamp the written window to 1..WINDOW_MAX.
   assign wr_wide = CMP_W'(csr_write_data);
   always_comb begin
      if (wr_wide == '0) begin
         window_in = FILL_W'(1);
      end else if (wr_wide > CMP_W'(WINDOW_MAX)) begin
         window_in = FILL_W'(WINDOW_MAX);
      end else begin
         window_in = wr_wide[FILL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= FILL_W'(1);
      end else if (csr_write_enable) begin
         window_ff <= window_in;
      end
   end

   always_comb begin
      pos_eff       = (FILL_W'(pos_ff[ch_ff]) >= window_ff) ? '0 : pos_ff[ch_ff];
      pos_next_wide = FILL_W'(pos_eff) + FILL_W'(1);
      pos_in        = (pos_next_wide >= window_ff) ? '0 : pos_next_wide[POS_W-1:0];
      full          = (fill_ff[ch_ff] >= window_ff);
      fill_in       = full ? fill_ff[ch_ff] : fill_ff[ch_ff] + FILL_W'(1);
      old_ext       = full ? SUM_W'(rd_data_ff) : '0;
      sum_in        = sum_ff[ch_ff] - old_ext + SUM_W'(sample_ff);
      addr          = {ch_ff, pos_eff};
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ch_ff     <= ch_map[in_channel];
         sample_ff <= in_sample;
      end
   end

   // Clear every channel on reset and on a window write.
   always_ff @(posedge clock) begin
      if (reset || csr_write_enable) begin
         for (int c = 0; c < CHANNELS; c++) begin
            pos_ff[c]  <= '0;
            fill_ff[c] <= '0;
            sum_ff[c]  <= '0;
         end
      end else if (cmd.update) begin
         pos_ff[ch_ff]  <= pos_in;
         fill_ff[ch_ff] <= fill_in;
         sum_ff[ch_ff]  <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         rd_data_ff <= ring[addr];
      end
      if (cmd.update) begin
         ring[addr] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         total_ff <= sum_in;
         count_ff <= fill_in;
      end
      if (cmd.div_start) begin
         neg_ff <= total_ff[SUM_W-1];
      end
   end

   assign magnitude = total_ff[SUM_W-1] ? SUM_W'(-total_ff) : SUM_W'(total_ff);

   mma_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (FILL_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (magnitude),
      .divisor  (count_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign quo_low   = quotient[SAMPLE_W-1:0];
   assign ch_wide   = {{CHANNEL_W{1'b0}}, ch_ff};
   assign used_wide = {{USED_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_channel_ff <= ch_wide[CHANNEL_W-1:0];
         out_average_ff <= neg_ff ? $signed(-quo_low) : $signed(quo_low);
         out_used_ff    <= used_wide[USED_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign status.div_busy = div_busy;
   assign status.out_free = !out_valid_ff || out_ready;
   assign out_valid       = out_valid_ff;
   assign out_channel     = out_channel_ff;
   assign out_average     = out_average_ff;
   assign out_used        = out_used_ff;

   a_used_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_used_ff != '0))
      else $error("result beat with zero sample count");

   a_div_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> div_busy)
      else $error("divider did not start");

   a_fill_after_update: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> ((fill_ff[ch_ff] != '0) || $past(csr_write_enable)))
      else $error("fill count empty after update");

endmodule
`default_nettype wire

// ===== src/multichannel_moving_average.sv =====
// Top level of the per-channel moving average block.
// Each accepted beat goes through these steps until its result is loaded: a read of the ring
// memory, an update of the channel's running sum, a load of the divider, the restoring divider
// at one quotient bit per cycle, a state in which the controller sees the divider finish, and
// the load of the output register. The next beat is accepted at the earliest in the cycle after
// that load, so the block takes no new beat while one is in flight; a result that is not
// taken holds the block in its last step. The sample ring is a single-port memory of
// CHANNELS x WINDOW_MAX entries (rounded up to powers of two) that is never cleared; per
// channel fill counts, write positions and running sums reset to zero and are cleared again
// by every csr write, which also sets the window, clamped to 1..WINDOW_MAX. The average is
// truncated toward zero. Write the csr only while no beat is in flight.
`default_nettype none
module multichannel_moving_average
   import mma_pkg::*;
#(
   parameter int CHANNELS   = 8,
   parameter int WINDOW_MAX = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_enable,
   input  wire logic [WINDOW_W-1:0] csr_write_data,
   mma_req_if.sink                  req_chan,
   mma_rsp_if.source                rsp_chan
);

   mma_cmd_type    cmd;
   mma_status_type status;
   logic           req_ready;

   mma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mma_dp #(
      .CHANNELS   (CHANNELS),
      .WINDOW_MAX (WINDOW_MAX)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .in_channel       (req_chan.channel),
      .in_sample        (req_chan.sample_value),
      .cmd              (cmd),
      .status           (status),
      .out_ready        (rsp_chan.ready),
      .out_valid        (rsp_chan.valid),
      .out_channel      (rsp_chan.result_channel),
      .out_average      (rsp_chan.average_value),
      .out_used         (rsp_chan.samples_used)
   );

   assign req_chan.ready = req_ready;

endmodule
`default_nettype wire
